// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on: a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SCT_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sct assertion failed");

// Checked on every rising edge, reset included.
`define SCT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("sct assertion failed");

`endif

// File: hw/rtl/sct_pkg.sv
// Shared types, constants and the translation table of the scancode translator.
// Depends on: nothing.
package sct_pkg;

    localparam int unsigned QUEUE_DEPTH = 1024;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_RESEND = 8'hFE;
    localparam logic [7:0] BYTE_IGNORE = 8'h7F;

    localparam logic [6:0] KEY_CTRL    = 7'd29;
    localparam logic [6:0] KEY_COMMAND = 7'd91;
    localparam logic [6:0] KEY_ALT     = 7'd56;
    localparam logic [6:0] KEY_LSHIFT  = 7'd42;
    localparam logic [6:0] KEY_RSHIFT  = 7'd54;
    localparam logic [6:0] KEY_CAPS    = 7'd58;
    localparam logic [6:0] KEY_NUM     = 7'd69;

    localparam logic [2:0] EV_IGNORED  = 3'd0;
    localparam logic [2:0] EV_ENQUEUED = 3'd1;
    localparam logic [2:0] EV_RESEND   = 3'd2;
    localparam logic [2:0] EV_DROPPED  = 3'd3;
    localparam logic [2:0] EV_POLL     = 3'd4;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] code;
    } queue_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // set-1 key index -> code, release bit excluded
    localparam logic [7:0] XLAT_ROM [128] = '{
        8'd0,   8'd1,   8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
        8'd55,  8'd56,  8'd57,  8'd48,  8'd45,  8'd61,  8'd14,  8'd9,
        8'd81,  8'd87,  8'd69,  8'd82,  8'd84,  8'd89,  8'd85,  8'd73,
        8'd79,  8'd80,  8'd91,  8'd93,  8'd10,  8'd29,  8'd65,  8'd83,
        8'd68,  8'd70,  8'd71,  8'd72,  8'd74,  8'd75,  8'd76,  8'd59,
        8'd39,  8'd96,  8'd42,  8'd92,  8'd90,  8'd88,  8'd67,  8'd86,
        8'd66,  8'd78,  8'd77,  8'd44,  8'd46,  8'd47,  8'd58,  8'd60,
        8'd62,  8'd32,  8'd63,  8'd64,  8'd94,  8'd95,  8'd97,  8'd98,
        8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106,
        8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112, 8'd113, 8'd114,
        8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122,
        8'd123, 8'd124, 8'd125, 8'd126, 8'd2,   8'd3,   8'd4,   8'd5,
        8'd6,   8'd7,   8'd8,   8'd11,  8'd12,  8'd13,  8'd15,  8'd16,
        8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,
        8'd25,  8'd26,  8'd27,  8'd28,  8'd30,  8'd31,  8'd33,  8'd34,
        8'd35,  8'd36,  8'd37,  8'd38,  8'd40,  8'd41,  8'd43,  8'd0
    };

    function automatic logic [4:0] mod_flag(input logic [6:0] key);
        logic [4:0] f;
        unique case (key)
            KEY_CTRL:    f = 5'b00001;
            KEY_COMMAND: f = 5'b00010;
            KEY_ALT:     f = 5'b00100;
            KEY_LSHIFT:  f = 5'b01000;
            KEY_RSHIFT:  f = 5'b10000;
            default:     f = 5'b00000;
        endcase
        return f;
    endfunction

    function automatic logic [1:0] lock_flag(input logic [6:0] key);
        logic [1:0] f;
        unique case (key)
            KEY_CAPS: f = 2'b01;
            KEY_NUM:  f = 2'b10;
            default:  f = 2'b00;
        endcase
        return f;
    endfunction

endpackage

// File: hw/rtl/scancode_translator_with_key_queue.sv
// Top level: scancode decode, modifier/lock tracking, key queue and result register.
// Depends on: sct_pkg, sct_queue.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------------
//  s_  in    | s_valid / s_ready     | s_action, s_scan_byte
//  m_  out   | m_valid / m_ready     | m_event_res, m_resend_byte,
//            |                       | m_translated_code, m_poll_valid,
//            |                       | m_modifiers, m_locks
//  cfg       | cfg_wr_en             | cfg_wr_data
//
// One word per cycle in, one result word per cycle out while m_ready holds; result appears the cycle after accept.
// The queue RAM read is issued at accept and lands in the RAM output register with the result.
// s_ready is high whenever the result register is empty or being taken by m_ready.
// Reset (aresetn, synchronous) clears pointers, modifiers, locks, command byte and m_valid.
module scancode_translator_with_key_queue (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_resend_byte,
    output logic [7:0] m_translated_code,
    output logic       m_poll_valid,
    output logic [4:0] m_modifiers,
    output logic [1:0] m_locks,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    sct_pkg::queue_req_t  q_req;
    sct_pkg::queue_stat_t q_stat;
    logic [7:0]           q_rd_data;

    logic       accept;
    logic [6:0] key;
    logic       rel;
    logic [4:0] mflag;
    logic [1:0] tflag;

    logic [7:0] last_cmd_reg;
    logic [4:0] mod_reg, mod_next;
    logic [1:0] lock_reg, lock_next;
    logic       valid_reg, valid_next;
    logic [2:0] event_reg, event_next;
    logic [7:0] resend_reg, resend_next;
    logic [7:0] code_reg, code_next;
    logic       from_ram_reg;
    logic       push, pop;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign key     = s_scan_byte[6:0];
    assign rel     = s_scan_byte[7];
    assign mflag   = sct_pkg::mod_flag(key);
    assign tflag   = sct_pkg::lock_flag(key);

    always_comb begin
        event_next  = sct_pkg::EV_IGNORED;
        resend_next = '0;
        code_next   = '0;
        mod_next    = mod_reg;
        lock_next   = lock_reg;
        push        = 1'b0;
        pop         = 1'b0;
        if (s_action) begin
            event_next = sct_pkg::EV_POLL;
            pop        = !q_stat.empty;
        end else if (s_scan_byte == sct_pkg::BYTE_ACK || s_scan_byte == sct_pkg::BYTE_IGNORE) begin
            event_next = sct_pkg::EV_IGNORED;
        end else if (s_scan_byte == sct_pkg::BYTE_RESEND) begin
            event_next  = sct_pkg::EV_RESEND;
            resend_next = last_cmd_reg;
        end else begin
            mod_next   = rel ? (mod_reg & ~mflag) : (mod_reg | mflag);
            lock_next  = rel ? (lock_reg ^ tflag) : lock_reg;
            code_next  = {rel, sct_pkg::XLAT_ROM[key][6:0]};
            push       = !q_stat.full;
            event_next = q_stat.full ? sct_pkg::EV_DROPPED : sct_pkg::EV_ENQUEUED;
        end
    end

    assign q_req.push = accept && push;
    assign q_req.pop  = accept && pop;
    assign q_req.code = code_next;

    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            last_cmd_reg <= '0;
            mod_reg      <= '0;
            lock_reg     <= '0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_wr_en) begin
                last_cmd_reg <= cfg_wr_data;
            end
            if (accept) begin
                mod_reg  <= mod_next;
                lock_reg <= lock_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            event_reg    <= event_next;
            resend_reg   <= resend_next;
            code_reg     <= code_next;
            from_ram_reg <= pop;
        end
    end

    sct_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (q_req),
        .stat    (q_stat),
        .rd_data (q_rd_data)
    );

    assign m_valid           = valid_reg;
    assign m_event_res       = event_reg;
    assign m_resend_byte     = resend_reg;
    assign m_translated_code = from_ram_reg ? q_rd_data : code_reg;
    assign m_poll_valid      = from_ram_reg;
    assign m_modifiers       = mod_reg;
    assign m_locks           = lock_reg;

endmodule

// File: hw/rtl/sct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on: nothing.
module sct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/sct_queue.sv
// Ring FIFO of translated key codes: pointers and full/empty status.
// Depends on: sct_pkg, sct_ram.
module sct_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sct_pkg::queue_req_t  req,
    output sct_pkg::queue_stat_t stat,
    output logic [7:0]           rd_data
);

    logic [sct_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sct_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sct_pkg::PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
    logic                      do_push, do_pop;

    assign wr_ptr_inc = (wr_ptr_reg == sct_pkg::PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == sct_pkg::PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

    assign stat.full  = (wr_ptr_inc == rd_ptr_reg);
    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);

    assign do_push = req.push && !stat.full;
    assign do_pop  = req.pop && !stat.empty;

    assign wr_ptr_next = do_push ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_inc : rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    sct_ram #(
        .WIDTH(8),
        .DEPTH(sct_pkg::QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (do_push),
        .wr_addr (wr_ptr_reg),
        .wr_data (req.code),
        .rd_en   (do_pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

endmodule

// File: hw/rtl/sct_checker.sv
// Port-level checker for the scancode translator, bound to the top level.
// Depends on: sct_pkg, assert_macros.svh.
`include "assert_macros.svh"

module sct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_event_res,
    input logic [7:0] m_resend_byte,
    input logic       m_poll_valid,
    input logic [4:0] m_modifiers,
    input logic [1:0] m_locks
);

    `SCT_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid)
    `SCT_ASSERT_ALWAYS(a_ready_when_empty, !m_valid |-> s_ready)
    `SCT_ASSERT(a_poll_valid_event, m_valid && m_poll_valid |-> m_event_res == sct_pkg::EV_POLL)
    `SCT_ASSERT(a_resend_zero, m_valid && m_event_res != sct_pkg::EV_RESEND |-> m_resend_byte == 8'd0)
    `SCT_ASSERT(a_mod_stable, !(s_valid && s_ready) |=> $stable(m_modifiers) && $stable(m_locks))

endmodule

bind scancode_translator_with_key_queue sct_checker u_sct_checker (.*);

// File: bench/tb.sv
// Testbench for scancode_translator_with_key_queue: directed and random scancode/poll words,
// checked word by word against a behavioral model of translation, modifiers, locks and key queue.
// Depends on: sct_pkg and the scancode_translator_with_key_queue RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] resend;
        logic [7:0] code;
        logic       pvalid;
        logic [4:0] mods;
        logic [1:0] locks;
    } key_event_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_action = 1'b0;
    logic [7:0] s_scan_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_event_res;
    logic [7:0] m_resend_byte;
    logic [7:0] m_translated_code;
    logic       m_poll_valid;
    logic [4:0] m_modifiers;
    logic [1:0] m_locks;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;

    // model state
    logic [7:0] set1_xlat [128];
    logic [7:0] model_key_queue [$];
    logic [7:0] cmd_byte = 8'h00;
    logic [4:0] mod_state = 5'b0;
    logic [1:0] lock_state = 2'b0;

    key_event_t due_key_events [$];
    key_event_t due_word;
    int         errors = 0;
    int         cycle_count = 0;
    bit         no_idle = 1'b0;
    int         hold_req = 0;
    int         hold_ack = 0;
    int         ready_stall = 0;

    scancode_translator_with_key_queue DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_scan_byte       (s_scan_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_res       (m_event_res),
        .m_resend_byte     (m_resend_byte),
        .m_translated_code (m_translated_code),
        .m_poll_valid      (m_poll_valid),
        .m_modifiers       (m_modifiers),
        .m_locks           (m_locks),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic void place_row(input int first, input string chars);
        for (int k = 0; k < chars.len(); k++)
            set1_xlat[(first + k) & 127] = chars[k];
    endfunction

    // printable keys fixed, each other index below 127 gets the first free code at or after it, wrapping mod 127
    function automatic void build_set1_xlat();
        bit taken [128];
        int v;
        for (int i = 0; i < 128; i++) begin
            set1_xlat[i] = 8'd0;
            taken[i] = 1'b0;
        end
        place_row(2, "1234567890-=");
        place_row(16, "QWERTYUIOP[]");
        place_row(30, "ASDFGHJKL;'");
        place_row(44, "ZXCVBNM,./");
        set1_xlat[15] = 8'd9;
        set1_xlat[28] = 8'd10;
        set1_xlat[41] = 8'd96;
        set1_xlat[43] = 8'd92;
        set1_xlat[57] = " ";
        for (int i = 0; i < 128; i++)
            if (set1_xlat[i] != 0) taken[set1_xlat[i] & 127] = 1'b1;
        for (int i = 0; i < 127; i++) begin
            if (set1_xlat[i] == 0) begin
                for (int j = 0; j < 127; j++) begin
                    v = (i + j) % 127;
                    if (!taken[v]) begin
                        set1_xlat[i] = 8'(v);
                        taken[v] = 1'b1;
                        break;
                    end
                end
            end
        end
    endfunction

    function automatic key_event_t translate_word(input logic action, input logic [7:0] sbyte);
        key_event_t r;
        logic [6:0] low;
        logic       rel;
        logic [4:0] mflag;
        logic [1:0] lflag;
        r = '0;
        low = sbyte[6:0];
        rel = sbyte[7];
        mflag = 5'b0;
        lflag = 2'b0;
        if (action) begin
            r.ev = sct_pkg::EV_POLL;
            if (model_key_queue.size() != 0) begin
                r.code = model_key_queue.pop_front();
                r.pvalid = 1'b1;
            end
        end else if (sbyte == sct_pkg::BYTE_ACK || sbyte == sct_pkg::BYTE_IGNORE) begin
            r.ev = sct_pkg::EV_IGNORED;
        end else if (sbyte == sct_pkg::BYTE_RESEND) begin
            r.ev = sct_pkg::EV_RESEND;
            r.resend = cmd_byte;
        end else begin
            case (low)
                sct_pkg::KEY_CTRL:    mflag = 5'b00001;
                sct_pkg::KEY_COMMAND: mflag = 5'b00010;
                sct_pkg::KEY_ALT:     mflag = 5'b00100;
                sct_pkg::KEY_LSHIFT:  mflag = 5'b01000;
                sct_pkg::KEY_RSHIFT:  mflag = 5'b10000;
                sct_pkg::KEY_CAPS:    lflag = 2'b01;
                sct_pkg::KEY_NUM:     lflag = 2'b10;
                default:              ;
            endcase
            if (mflag != 0) mod_state = rel ? (mod_state & ~mflag) : (mod_state | mflag);
            if (lflag != 0 && rel) lock_state = lock_state ^ lflag;
            r.code = {rel, set1_xlat[low][6:0]};
            if (model_key_queue.size() >= sct_pkg::QUEUE_DEPTH - 1) begin
                r.ev = sct_pkg::EV_DROPPED;
            end else begin
                model_key_queue.push_back(r.code);
                r.ev = sct_pkg::EV_ENQUEUED;
            end
        end
        r.mods = mod_state;
        r.locks = lock_state;
        return r;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_pause();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls plus requested long hold-offs
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            ready_stall = HOLD_CYCLES;
        end
        if (ready_stall > 0) begin
            m_ready <= 1'b0;
            ready_stall = ready_stall - 1;
        end else begin
            ready_stall = pick_pause();
            if (ready_stall > 0) begin
                m_ready <= 1'b0;
                ready_stall = ready_stall - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected 0x%02h got 0x%02h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_key_events.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                due_word = due_key_events.pop_front();
                check_field("m_event_res", 8'(due_word.ev), 8'(m_event_res));
                check_field("m_resend_byte", due_word.resend, m_resend_byte);
                check_field("m_translated_code", due_word.code, m_translated_code);
                check_field("m_poll_valid", 8'(due_word.pvalid), 8'(m_poll_valid));
                check_field("m_modifiers", 8'(due_word.mods), 8'(m_modifiers));
                check_field("m_locks", 8'(due_word.locks), 8'(m_locks));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("scancode_translator_with_key_queue verification failed");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic action, input logic [7:0] sbyte);
        int pause;
        s_valid <= 1'b1;
        s_action <= action;
        s_scan_byte <= sbyte;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due_key_events.push_back(translate_word(action, sbyte));
        @(negedge aclk);
        pause = pick_pause();
        if (pause > 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(negedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (due_key_events.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cmd_byte(input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cmd_byte = value;
    endtask

    function automatic logic [6:0] pick_state_key();
        case ($urandom_range(0, 6))
            0:       return sct_pkg::KEY_CTRL;
            1:       return sct_pkg::KEY_COMMAND;
            2:       return sct_pkg::KEY_ALT;
            3:       return sct_pkg::KEY_LSHIFT;
            4:       return sct_pkg::KEY_RSHIFT;
            5:       return sct_pkg::KEY_CAPS;
            default: return sct_pkg::KEY_NUM;
        endcase
    endfunction

    // press a modifier or lock, type a few keys, release it
    task automatic send_key_sequence();
        logic [6:0] key;
        key = pick_state_key();
        send_word(1'b0, {1'b0, key});
        repeat ($urandom_range(1, 4)) send_word(1'b0, 8'($urandom_range(0, 255)));
        send_word(1'b0, {1'b1, key});
    endtask

    task automatic send_random(input int poll_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < poll_pct) begin
            send_word(1'b1, 8'($urandom_range(0, 255)));
        end else if (r < poll_pct + 8) begin
            case ($urandom_range(0, 3))
                0:       send_word(1'b0, sct_pkg::BYTE_ACK);
                1:       send_word(1'b0, sct_pkg::BYTE_RESEND);
                2:       send_word(1'b0, sct_pkg::BYTE_IGNORE);
                default: send_word(1'b0, 8'hFF);
            endcase
        end else if (r < poll_pct + 30) begin
            send_key_sequence();
        end else begin
            send_word(1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_directed();
        send_word(1'b1, 8'h00);
        send_word(1'b0, sct_pkg::BYTE_ACK);
        send_word(1'b0, sct_pkg::BYTE_IGNORE);
        send_word(1'b0, sct_pkg::BYTE_RESEND);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h80);
        send_word(1'b0, {1'b0, sct_pkg::KEY_CTRL});
        send_word(1'b0, {1'b0, sct_pkg::KEY_COMMAND});
        send_word(1'b0, {1'b0, sct_pkg::KEY_ALT});
        send_word(1'b0, {1'b0, sct_pkg::KEY_LSHIFT});
        send_word(1'b0, {1'b0, sct_pkg::KEY_RSHIFT});
        send_word(1'b0, {1'b0, sct_pkg::KEY_CAPS});
        send_word(1'b0, {1'b1, sct_pkg::KEY_CAPS});
        send_word(1'b0, {1'b0, sct_pkg::KEY_NUM});
        send_word(1'b0, {1'b1, sct_pkg::KEY_NUM});
        send_word(1'b0, {1'b1, sct_pkg::KEY_CTRL});
        send_word(1'b0, {1'b1, sct_pkg::KEY_ALT});
        send_word(1'b1, 8'hFF);
        send_word(1'b1, 8'h5A);
        send_word(1'b1, 8'h00);
    endtask

    task automatic test_command_byte();
        logic [7:0] values [4];
        values[0] = 8'hFF;
        values[1] = 8'h00;
        values[2] = 8'hA5;
        values[3] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 4; i++) begin
            wait_drain();
            write_cmd_byte(values[i]);
            send_word(1'b0, sct_pkg::BYTE_RESEND);
            send_word(1'b0, 8'($urandom_range(0, 255)));
            send_word(1'b0, sct_pkg::BYTE_RESEND);
        end
    endtask

    // long receiver hold-off while words keep coming
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_req = hold_req + 1;
        repeat (24) send_random(30);
        no_idle = 1'b0;
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 60; i++) begin
            no_idle = (i >= 25 && i < 40);
            send_random(45);
        end
        no_idle = 1'b0;
    endtask

    // fill to the brim, then keep pushing so codes get dropped
    task automatic test_queue_full();
        while (model_key_queue.size() < sct_pkg::QUEUE_DEPTH - 1) send_random(5);
        repeat (30) send_random(5);
    endtask

    // drain a good part of the queue, then mix polls and codes
    task automatic test_queue_drain();
        while (model_key_queue.size() > 450) send_random(95);
        repeat (20) send_random(50);
    endtask

    initial begin
        build_set1_xlat();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_command_byte();
        test_backpressure();
        test_random_mix();
        test_queue_full();
        test_queue_drain();
        wait_drain();
        repeat (10) @(negedge aclk);
        if (errors == 0) begin
            $display("scancode_translator_with_key_queue verification clean");
        end else begin
            $display("scancode_translator_with_key_queue verification failed");
        end
        $finish;
    end

endmodule
